>>> rtl/core/hpd_pkg.sv
// ----------------------------------------------------------------------------
// hpd_pkg: shared types and constants of the hysteresis peak detector
// Sample, index and threshold widths, the phase encoding, and the structs
// passed between the input stage, the tracker and the result stage.
// ----------------------------------------------------------------------------
package hpd_pkg;

    localparam int SAMPLE_WIDTH    = 16;
    localparam int INDEX_WIDTH     = 16;
    localparam int THRESHOLD_WIDTH = 16;
    localparam int CMP_WIDTH       =
        ((SAMPLE_WIDTH > THRESHOLD_WIDTH) ? SAMPLE_WIDTH : THRESHOLD_WIDTH) + 2;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic [INDEX_WIDTH-1:0]         index_t;
    typedef logic [THRESHOLD_WIDTH-1:0]     threshold_t;
    typedef logic signed [CMP_WIDTH-1:0]    cmp_t;

    localparam index_t INDEX_MAX = '1;

    typedef enum logic [2:0] {
        PH_UNDECIDED = 3'b001,
        PH_RISING    = 3'b010,
        PH_FALLING   = 3'b100
    } phase_t;

    typedef struct packed {
        sample_t sample;
        logic    restart;
    } item_t;

    typedef struct packed {
        logic   fire;
        index_t index;
    } peak_t;

endpackage

>>> rtl/core/hpd_in_stage.sv
// ----------------------------------------------------------------------------
// hpd_in_stage: input register
// Captures one input transfer per cycle and holds it until the tracker
// advances.
// ----------------------------------------------------------------------------
module hpd_in_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  hpd_pkg::item_t in_item,
    input  logic           advance,
    output logic           stage_valid,
    output hpd_pkg::item_t stage_item
);

    logic           valid_reg;
    logic           valid_next;
    hpd_pkg::item_t item_reg;

    assign in_ready    = !valid_reg || advance;
    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> rtl/core/hpd_track.sv
// ----------------------------------------------------------------------------
// hpd_track: hysteresis tracker
// Holds phase, running maximum and minimum with their indexes and the
// sample count; decides in one pass whether the current sample confirms
// a peak.
// ----------------------------------------------------------------------------
module hpd_track
(
    input  logic                clk,
    input  logic                rst_n,
    input  hpd_pkg::item_t      item,
    input  hpd_pkg::threshold_t threshold,
    input  logic                step,
    output hpd_pkg::peak_t      peak
);

    hpd_pkg::phase_t  phase_reg;
    hpd_pkg::phase_t  phase_next;
    hpd_pkg::sample_t max_value_reg;
    hpd_pkg::sample_t max_value_next;
    hpd_pkg::index_t  max_index_reg;
    hpd_pkg::index_t  max_index_next;
    hpd_pkg::sample_t min_value_reg;
    hpd_pkg::sample_t min_value_next;
    hpd_pkg::index_t  min_index_reg;
    hpd_pkg::index_t  min_index_next;
    hpd_pkg::index_t  sample_count_reg;
    hpd_pkg::index_t  sample_count_next;
    logic             seen_first_reg;

    logic             rs;
    hpd_pkg::phase_t  cur_phase;
    hpd_pkg::sample_t cur_max;
    hpd_pkg::index_t  cur_max_index;
    hpd_pkg::sample_t cur_min;
    hpd_pkg::index_t  cur_min_index;
    hpd_pkg::index_t  cur_count;
    hpd_pkg::cmp_t    xe;
    hpd_pkg::cmp_t    thr_e;
    hpd_pkg::cmp_t    max_e;
    hpd_pkg::cmp_t    min_e;
    logic             fall_hit;
    logic             rise_hit;
    logic             fire;

    always_comb
    begin
        rs            = item.restart || !seen_first_reg;
        cur_phase     = rs ? hpd_pkg::PH_UNDECIDED : phase_reg;
        cur_max       = rs ? item.sample : max_value_reg;
        cur_max_index = rs ? '0 : max_index_reg;
        cur_min       = rs ? item.sample : min_value_reg;
        cur_min_index = rs ? '0 : min_index_reg;
        cur_count     = rs ? '0 : sample_count_reg;

        xe    = hpd_pkg::cmp_t'(item.sample);
        thr_e = hpd_pkg::cmp_t'(threshold);
        max_e = hpd_pkg::cmp_t'(cur_max);
        min_e = hpd_pkg::cmp_t'(cur_min);

        fall_hit = (xe + thr_e) <= max_e;
        rise_hit = xe >= (min_e + thr_e);

        phase_next     = cur_phase;
        max_value_next = cur_max;
        max_index_next = cur_max_index;
        min_value_next = cur_min;
        min_index_next = cur_min_index;
        fire           = 1'b0;

        case (cur_phase)
            hpd_pkg::PH_UNDECIDED:
            begin
                if (fall_hit)
                begin
                    phase_next = hpd_pkg::PH_FALLING;
                end
                else if (rise_hit)
                begin
                    phase_next = hpd_pkg::PH_RISING;
                end
                if (xe >= max_e)
                begin
                    max_value_next = item.sample;
                    max_index_next = cur_count;
                end
                else if (xe <= min_e)
                begin
                    min_value_next = item.sample;
                    min_index_next = cur_count;
                end
            end
            hpd_pkg::PH_RISING:
            begin
                if (max_e <= xe)
                begin
                    max_value_next = item.sample;
                    max_index_next = cur_count;
                end
                else if (fall_hit)
                begin
                    fire           = 1'b1;
                    min_value_next = item.sample;
                    min_index_next = cur_count;
                    phase_next     = hpd_pkg::PH_FALLING;
                end
            end
            hpd_pkg::PH_FALLING:
            begin
                if (xe <= min_e)
                begin
                    min_value_next = item.sample;
                    min_index_next = cur_count;
                end
                else if (rise_hit)
                begin
                    max_value_next = item.sample;
                    max_index_next = cur_count;
                    phase_next     = hpd_pkg::PH_RISING;
                end
            end
            default:
            begin
            end
        endcase

        sample_count_next = (cur_count == hpd_pkg::INDEX_MAX) ? cur_count
                                                                : cur_count + 1'b1;
    end

    assign peak.fire  = fire;
    assign peak.index = cur_max_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= hpd_pkg::PH_UNDECIDED;
            max_value_reg    <= '0;
            max_index_reg    <= '0;
            min_value_reg    <= '0;
            min_index_reg    <= '0;
            sample_count_reg <= '0;
            seen_first_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            max_value_reg    <= max_value_next;
            max_index_reg    <= max_index_next;
            min_value_reg    <= min_value_next;
            min_index_reg    <= min_index_next;
            sample_count_reg <= sample_count_next;
            seen_first_reg   <= 1'b1;
        end
    end

    // saturated count holds unless a new sequence starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && !rs && sample_count_reg == hpd_pkg::INDEX_MAX)
        |=> (sample_count_reg == hpd_pkg::INDEX_MAX))
        else $error("sample count left saturation without restart");

    // a confirmed peak always leaves the tracker falling
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && fire) |=> (phase_reg == hpd_pkg::PH_FALLING))
        else $error("peak confirmed without entering falling phase");

    // a peak is never confirmed on the first sample of a sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        rs |-> !fire)
        else $error("peak confirmed on a restart sample");

endmodule

>>> rtl/core/hpd_out_stage.sv
// ----------------------------------------------------------------------------
// hpd_out_stage: result register
// Holds one confirmed peak index until the downstream transfer completes.
// ----------------------------------------------------------------------------
module hpd_out_stage
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  hpd_pkg::index_t  load_index,
    output logic             slot_free,
    output logic             out_valid,
    input  logic             out_ready,
    output hpd_pkg::index_t  peak_index
);

    logic            valid_reg;
    logic            valid_next;
    hpd_pkg::index_t index_reg;

    assign slot_free  = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign peak_index = index_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg <= load_index;
        end
    end

endmodule

>>> rtl/core/hysteresis_peak_detector.sv
// ----------------------------------------------------------------------------
// hysteresis_peak_detector: hysteresis peak detector top level
// One signed sample per transfer in; the sample index of each confirmed
// maximum out.
// ----------------------------------------------------------------------------
// The block takes one sample transfer every clock cycle unless a confirming
// sample is stalled as described below. A peak index reaches the result port
// from the input register through the tracker, which decides straight into
// the result register. The rate is set by the tracker's update of phase,
// extrema and count, which every sample passes through in order. A sample
// that confirms a peak waits in the input register while the result register
// is full and not being taken; other samples keep flowing. Set restart on a
// sample to begin a new sequence at index 0; the first sample after reset
// always does. Write threshold only while the block is idle.
// ----------------------------------------------------------------------------
module hysteresis_peak_detector
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  hpd_pkg::sample_t    sample,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_ready,
    output hpd_pkg::index_t     peak_index,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  hpd_pkg::threshold_t threshold
);

    hpd_pkg::threshold_t threshold_reg;
    hpd_pkg::item_t      in_item;
    hpd_pkg::item_t      stage_item;
    hpd_pkg::peak_t      peak;
    logic                stage_valid;
    logic                stage_adv;
    logic                slot_free;
    logic                out_load;

    assign cfg_ready       = 1'b1;
    assign in_item.sample  = sample;
    assign in_item.restart = restart;

    assign stage_adv = stage_valid && (!peak.fire || slot_free);
    assign out_load  = stage_adv && peak.fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= threshold;
        end
    end

    hpd_in_stage u_in_stage
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .advance     (stage_adv),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    hpd_track u_track
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (stage_item),
        .threshold (threshold_reg),
        .step      (stage_adv),
        .peak      (peak)
    );

    hpd_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (out_load),
        .load_index (peak.index),
        .slot_free  (slot_free),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .peak_index (peak_index)
    );

    // never overwrite a pending result
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !out_load)
        else $error("result register overwritten while stalled");

    // a new result appears only from a loaded peak
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(out_load))
        else $error("result valid without a confirmed peak");

    // a held sample that blocks input must be a stalled peak
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid && !in_ready) |-> (peak.fire && out_valid && !out_ready))
        else $error("input stalled without a pending peak");

endmodule
